// ----- sv/quicksort_lomuto_sorter_unit_defines.svh -----
// Assertion macros used by the sorter's controller.
`ifndef QUICKSORT_LOMUTO_SORTER_UNIT_DEFINES_SVH
`define QUICKSORT_LOMUTO_SORTER_UNIT_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define QSL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The condition must hold in the cycle after the trigger.
`define QSL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/qsl_pkg.sv -----
// Package with the sorter's constants, payload types and control types.
`timescale 1ns / 1ps

package qsl_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int VALUE_WIDTH  = 32;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int STACK_W      = 2 * IDX_W;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] data_value;
        logic                          is_last;
    } in_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] sorted_value;
        logic                          last_of_run;
        logic                          overflow;
    } out_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT,
        ST_POP,
        ST_POP_DATA,
        ST_PIVOT,
        ST_READ,
        ST_CMP,
        ST_SWAP_J,
        ST_FIN_HI,
        ST_PUSH_LO,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    // Requests from the controller to the element store and the range stack.
    typedef struct packed {
        logic                   store_we;
        logic [IDX_W-1:0]       store_waddr;
        logic [VALUE_WIDTH-1:0] store_wdata;
        logic [IDX_W-1:0]       store_raddr_a;
        logic [IDX_W-1:0]       store_raddr_b;
        logic                   stack_we;
        logic [IDX_W-1:0]       stack_waddr;
        logic [STACK_W-1:0]     stack_wdata;
        logic [IDX_W-1:0]       stack_raddr;
    } mem_req_t;

endpackage

// ----- sv/quicksort_lomuto_sorter_unit.sv -----
// Top level of the quicksort sorter: memories, controller and result register.
`timescale 1ns / 1ps

// Collects up to 64 signed values, one request per cycle, until a request with
// is_last arrives; values beyond 64 are dropped and flag overflow on every
// result of that set. The set is then sorted in place by Lomuto quicksort with
// an explicit range stack, and the values come out in ascending order with
// last_of_run on the greatest. Sorting is bound by the single write port of the
// element store: each compare reads an element and then compares it, each
// forward swap adds one more write, and each partition adds pop, pivot read and
// push overhead; sets already in order take longest. Each result is read from
// the store and then loaded into the result register, which waits while the
// output is stalled. No input request is taken from the last value of a set
// until its final result is registered.

module quicksort_lomuto_sorter_unit (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  qsl_pkg::in_t  s_payload,
    output logic          m_valid,
    input  logic          m_ready,
    output qsl_pkg::out_t m_payload
);

    import qsl_pkg::*;

    mem_req_t               mem_req;
    logic [VALUE_WIDTH-1:0] store_rdata_a;
    logic [VALUE_WIDTH-1:0] store_rdata_b;
    logic [STACK_W-1:0]     stack_rdata;
    logic                   out_free;
    logic                   out_load;
    out_t                   out_item;
    logic                   m_valid_reg, m_valid_next;
    out_t                   m_payload_reg, m_payload_next;

    // Two copies of the element store, written together, give two read ports.
    qsl_ram #(.DEPTH(MAX_ELEMENTS), .WIDTH(VALUE_WIDTH)) u_store_a (
        .aclk  (aclk),
        .we    (mem_req.store_we),
        .waddr (mem_req.store_waddr),
        .wdata (mem_req.store_wdata),
        .raddr (mem_req.store_raddr_a),
        .rdata (store_rdata_a)
    );

    qsl_ram #(.DEPTH(MAX_ELEMENTS), .WIDTH(VALUE_WIDTH)) u_store_b (
        .aclk  (aclk),
        .we    (mem_req.store_we),
        .waddr (mem_req.store_waddr),
        .wdata (mem_req.store_wdata),
        .raddr (mem_req.store_raddr_b),
        .rdata (store_rdata_b)
    );

    qsl_ram #(.DEPTH(MAX_ELEMENTS), .WIDTH(STACK_W)) u_stack (
        .aclk  (aclk),
        .we    (mem_req.stack_we),
        .waddr (mem_req.stack_waddr),
        .wdata (mem_req.stack_wdata),
        .raddr (mem_req.stack_raddr),
        .rdata (stack_rdata)
    );

    qsl_sort_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_payload     (s_payload),
        .s_ready       (s_ready),
        .out_free      (out_free),
        .out_load      (out_load),
        .out_item      (out_item),
        .store_rdata_a (store_rdata_a),
        .store_rdata_b (store_rdata_b),
        .stack_rdata   (stack_rdata),
        .mem_req       (mem_req)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next   = m_valid_reg;
        m_payload_next = m_payload_reg;
        if (out_load) begin
            m_valid_next   = 1'b1;
            m_payload_next = out_item;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_payload_reg <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

// ----- sv/qsl_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module qsl_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/qsl_sort_ctrl.sv -----
// Sequencer for loading, Lomuto partitioning with a range stack, and emission.
`timescale 1ns / 1ps
`include "quicksort_lomuto_sorter_unit_defines.svh"

module qsl_sort_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  qsl_pkg::in_t                    s_payload,
    output logic                            s_ready,
    input  logic                            out_free,
    output logic                            out_load,
    output qsl_pkg::out_t                   out_item,
    input  logic [qsl_pkg::VALUE_WIDTH-1:0] store_rdata_a,
    input  logic [qsl_pkg::VALUE_WIDTH-1:0] store_rdata_b,
    input  logic [qsl_pkg::STACK_W-1:0]     stack_rdata,
    output qsl_pkg::mem_req_t               mem_req
);

    import qsl_pkg::*;

    state_t                        state_reg, state_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic                          ovf_reg, ovf_next;
    logic [CNT_W-1:0]              sp_reg, sp_next;
    logic [IDX_W-1:0]              lo_reg, lo_next;
    logic [IDX_W-1:0]              hi_reg, hi_next;
    logic [IDX_W-1:0]              j_reg, j_next;
    logic [IDX_W-1:0]              fill_reg, fill_next;
    logic [IDX_W-1:0]              k_reg, k_next;
    logic signed [VALUE_WIDTH-1:0] pivot_reg, pivot_next;
    logic [VALUE_WIDTH-1:0]        swap_reg, swap_next;

    logic                          accept;
    logic                          store_room;
    logic [CNT_W-1:0]              sp_dec;
    logic                          stack_room;
    logic [IDX_W-1:0]              pop_lo, pop_hi;
    logic                          pop_skip;
    logic                          scan_done;
    logic                          elem_less;
    logic                          push_right, push_left;
    logic                          emit_last;

    assign accept     = s_valid && s_ready;
    assign store_room = count_reg < CNT_W'(MAX_ELEMENTS);
    assign sp_dec     = sp_reg - 1'b1;
    assign stack_room = sp_reg < CNT_W'(MAX_ELEMENTS);
    assign pop_lo     = stack_rdata[STACK_W-1:IDX_W];
    assign pop_hi     = stack_rdata[IDX_W-1:0];
    assign pop_skip   = (pop_lo >= pop_hi) || ({1'b0, pop_hi} >= count_reg);
    assign scan_done  = j_reg == hi_reg;
    assign elem_less  = $signed(store_rdata_a) < pivot_reg;
    // The split point is fill_reg once the scan has finished.
    assign push_right = ({1'b0, fill_reg} + 1'b1) < {1'b0, hi_reg};
    assign push_left  = {1'b0, fill_reg} > ({1'b0, lo_reg} + 1'b1);
    assign emit_last  = ({1'b0, k_reg} + 1'b1) == count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            sp_reg    <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            sp_reg    <= sp_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        j_reg     <= j_next;
        fill_reg  <= fill_next;
        k_reg     <= k_next;
        pivot_reg <= pivot_next;
        swap_reg  <= swap_next;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (accept && s_payload.is_last) begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:     state_next = ST_POP;
            ST_POP:      state_next = (sp_reg == '0) ? ST_EMIT_RD : ST_POP_DATA;
            ST_POP_DATA: state_next = pop_skip ? ST_POP : ST_PIVOT;
            ST_PIVOT:    state_next = ST_READ;
            ST_READ:     state_next = ST_CMP;
            ST_CMP: begin
                if (scan_done) begin
                    state_next = ST_FIN_HI;
                end else if (elem_less) begin
                    state_next = ST_SWAP_J;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_SWAP_J:   state_next = ST_READ;
            ST_FIN_HI:   state_next = ST_PUSH_LO;
            ST_PUSH_LO:  state_next = ST_POP;
            ST_EMIT_RD:  state_next = ST_EMIT_LD;
            ST_EMIT_LD: begin
                if (out_free) begin
                    state_next = emit_last ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default:     state_next = ST_LOAD;
        endcase
    end

    // Memory requests and channel outputs.
    always_comb begin
        s_ready               = 1'b0;
        out_load              = 1'b0;
        out_item.sorted_value = store_rdata_a;
        out_item.last_of_run  = emit_last;
        out_item.overflow     = ovf_reg;
        mem_req               = '0;
        mem_req.store_raddr_a = j_reg;
        mem_req.store_raddr_b = fill_reg;
        mem_req.stack_waddr   = sp_reg[IDX_W-1:0];
        mem_req.stack_raddr   = sp_dec[IDX_W-1:0];
        case (state_reg)
            ST_LOAD: begin
                s_ready             = 1'b1;
                mem_req.store_we    = accept && store_room;
                mem_req.store_waddr = count_reg[IDX_W-1:0];
                mem_req.store_wdata = s_payload.data_value;
            end
            ST_INIT: begin
                mem_req.stack_we    = count_reg >= CNT_W'(2);
                mem_req.stack_waddr = '0;
                mem_req.stack_wdata = {{IDX_W{1'b0}}, IDX_W'(count_reg - 1'b1)};
            end
            ST_POP_DATA: begin
                mem_req.store_raddr_a = pop_hi;
            end
            ST_CMP: begin
                mem_req.store_waddr = fill_reg;
                if (scan_done) begin
                    mem_req.store_we    = 1'b1;
                    mem_req.store_wdata = pivot_reg;
                end else if (elem_less) begin
                    mem_req.store_we    = 1'b1;
                    mem_req.store_wdata = store_rdata_a;
                end
            end
            ST_SWAP_J: begin
                mem_req.store_we    = 1'b1;
                mem_req.store_waddr = j_reg;
                mem_req.store_wdata = swap_reg;
            end
            ST_FIN_HI: begin
                mem_req.store_we    = 1'b1;
                mem_req.store_waddr = hi_reg;
                mem_req.store_wdata = swap_reg;
                mem_req.stack_we    = push_right && stack_room;
                mem_req.stack_wdata = {fill_reg + 1'b1, hi_reg};
            end
            ST_PUSH_LO: begin
                mem_req.stack_we    = push_left && stack_room;
                mem_req.stack_wdata = {lo_reg, fill_reg - 1'b1};
            end
            ST_EMIT_RD: begin
                mem_req.store_raddr_a = k_reg;
            end
            ST_EMIT_LD: begin
                mem_req.store_raddr_a = k_reg;
                out_load              = out_free;
            end
            default: begin
            end
        endcase
    end

    // Datapath register updates.
    always_comb begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        sp_next    = sp_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        j_next     = j_reg;
        fill_next  = fill_reg;
        k_next     = k_reg;
        pivot_next = pivot_reg;
        swap_next  = swap_reg;
        case (state_reg)
            ST_LOAD: begin
                if (accept) begin
                    if (store_room) begin
                        count_next = count_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
            end
            ST_INIT: begin
                sp_next = (count_reg >= CNT_W'(2)) ? CNT_W'(1) : '0;
            end
            ST_POP: begin
                k_next = '0;
                if (sp_reg != '0) begin
                    sp_next = sp_dec;
                end
            end
            ST_POP_DATA: begin
                lo_next   = pop_lo;
                hi_next   = pop_hi;
                j_next    = pop_lo;
                fill_next = pop_lo;
            end
            ST_PIVOT: begin
                pivot_next = store_rdata_a;
            end
            ST_CMP: begin
                swap_next = store_rdata_b;
                if (!scan_done && !elem_less) begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_SWAP_J: begin
                j_next    = j_reg + 1'b1;
                fill_next = fill_reg + 1'b1;
            end
            ST_FIN_HI: begin
                if (push_right && stack_room) begin
                    sp_next = sp_reg + 1'b1;
                end
            end
            ST_PUSH_LO: begin
                if (push_left && stack_room) begin
                    sp_next = sp_reg + 1'b1;
                end
            end
            ST_EMIT_LD: begin
                if (out_free) begin
                    if (emit_last) begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        sp_next    = '0;
                    end else begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    `QSL_ASSERT_SAME(a_scan_order,
        (state_reg == ST_READ || state_reg == ST_CMP || state_reg == ST_SWAP_J),
        (fill_reg <= j_reg) && (j_reg <= hi_reg),
        "partition indices out of order")
    `QSL_ASSERT_NEXT(a_last_starts_sort, accept && s_payload.is_last,
        (state_reg == ST_INIT) && !s_ready,
        "last request did not start the sort")
    `QSL_ASSERT_SAME(a_push_in_bounds, mem_req.stack_we,
        sp_reg < CNT_W'(MAX_ELEMENTS), "range stack written beyond its depth")
    `QSL_ASSERT_NEXT(a_final_result_clears, out_load && out_item.last_of_run,
        (count_reg == '0) && !ovf_reg && (state_reg == ST_LOAD),
        "set not cleared after its final result")

endmodule

// ----- verif/quicksort_lomuto_sorter_unit_test.sv -----
// Self-checking testbench for the quicksort sorter: directed, limit, stall and random sets.
`timescale 1ns / 1ps

module quicksort_lomuto_sorter_unit_test;
    import qsl_pkg::*;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;

    typedef enum int {
        PAT_RANDOM,
        PAT_ASCENDING,
        PAT_DESCENDING,
        PAT_EQUAL
    } set_pattern_t;

    localparam value_t VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam value_t VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam int HOLD_CYCLES = 600;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t s_payload = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_payload;

    // Values of the set being collected, as the block should hold them.
    value_t held_values[MAX_ELEMENTS];
    int held_count = 0;
    bit held_overflow = 1'b0;
    out_t expected_sorted[$];

    int check_failures = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    quicksort_lomuto_sorter_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always #2 aclk = ~aclk;

    function automatic int partition_range(int lo, int hi);
        value_t pivot;
        value_t tmp;
        int fill;
        pivot = held_values[hi];
        fill = lo;
        for (int j = lo; j < hi; j++) begin
            if (held_values[j] < pivot) begin
                tmp = held_values[fill];
                held_values[fill] = held_values[j];
                held_values[j] = tmp;
                fill++;
            end
        end
        tmp = held_values[fill];
        held_values[fill] = held_values[hi];
        held_values[hi] = tmp;
        return fill;
    endfunction

    function automatic void sort_held_values();
        int pending_lo[$];
        int pending_hi[$];
        int lo;
        int hi;
        int split;
        if (held_count >= 2) begin
            pending_lo.push_back(0);
            pending_hi.push_back(held_count - 1);
        end
        while (pending_lo.size() > 0) begin
            lo = pending_lo.pop_back();
            hi = pending_hi.pop_back();
            if (lo < hi) begin
                split = partition_range(lo, hi);
                if (split + 1 < hi) begin
                    pending_lo.push_back(split + 1);
                    pending_hi.push_back(hi);
                end
                if (split > lo + 1) begin
                    pending_lo.push_back(lo);
                    pending_hi.push_back(split - 1);
                end
            end
        end
    endfunction

    // Called for every accepted request; a last request releases the whole set.
    function automatic void predict_request(in_t req);
        out_t res;
        if (held_count < MAX_ELEMENTS) begin
            held_values[held_count] = req.data_value;
            held_count++;
        end else begin
            held_overflow = 1'b1;
        end
        if (!req.is_last)
            return;
        sort_held_values();
        for (int k = 0; k < held_count; k++) begin
            res.sorted_value = held_values[k];
            res.last_of_run = (k == held_count - 1);
            res.overflow = held_overflow;
            expected_sorted.push_back(res);
        end
        held_count = 0;
        held_overflow = 1'b0;
    endfunction

    // Entered and left at a falling edge; valid stays up between back-to-back requests.
    task automatic send_request(input value_t value, input logic last);
        int gap;
        in_t req;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        req.data_value = value;
        req.is_last = last;
        s_valid <= 1'b1;
        s_payload <= req;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predict_request(req);
        @(negedge aclk);
    endtask

    function automatic value_t random_value();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: return VALUE_MAX;
                    1: return VALUE_MIN;
                    2: return '0;
                    3: return '1;
                    default: return value_t'(1);
                endcase
            end
            1, 2: return value_t'($urandom_range(0, 7)) - value_t'(4);
            default: return value_t'($urandom());
        endcase
    endfunction

    task automatic send_set(input int size, input set_pattern_t pattern);
        value_t base;
        value_t value;
        base = random_value();
        for (int i = 0; i < size; i++) begin
            case (pattern)
                PAT_ASCENDING: value = base + value_t'(i);
                PAT_DESCENDING: value = base - value_t'(i);
                PAT_EQUAL: value = base;
                default: value = random_value();
            endcase
            send_request(value, i == size - 1);
        end
    endtask

    task automatic wait_for_results(input int settle);
        s_valid <= 1'b0;
        while (expected_sorted.size() != 0)
            @(negedge aclk);
        repeat (settle) @(negedge aclk);
    endtask

    task automatic test_small_sets();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        send_request(VALUE_MAX, 1'b1);
        send_request(VALUE_MIN, 1'b1);
        send_request(VALUE_MAX, 1'b0);
        send_request(VALUE_MIN, 1'b1);
        send_request(value_t'(1), 1'b0);
        send_request('1, 1'b0);
        send_request('0, 1'b0);
        send_request(VALUE_MAX, 1'b0);
        send_request(VALUE_MIN, 1'b1);
        // Repeated keys exercise the strict less-than of the partition.
        send_request(value_t'(3), 1'b0);
        send_request(value_t'(3), 1'b0);
        send_request(-value_t'(3), 1'b0);
        send_request(value_t'(3), 1'b0);
        send_request(-value_t'(3), 1'b1);
        send_set(4, PAT_EQUAL);
        send_set(5, PAT_DESCENDING);
        wait_for_results(4);
    endtask

    // A set that fills the store and then overruns it, losing its last value.
    task automatic test_store_limits();
        sender_idle_pct = 8;
        receiver_stall_pct = 8;
        send_set(MAX_ELEMENTS + 1, PAT_RANDOM);
        send_set(2, PAT_ASCENDING);
        wait_for_results(4);
    endtask

    task automatic test_backpressure();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_requests++;
        for (int i = 0; i < 3; i++)
            send_set(4, PAT_RANDOM);
        wait_for_results(4);
    endtask

    task automatic test_random_sets();
        int phase_idle[4] = '{0, 78, 0, 8};
        int phase_stall[4] = '{0, 0, 78, 8};
        int sent;
        int size;
        set_pattern_t pattern;
        for (int p = 0; p < 4; p++) begin
            sender_idle_pct = phase_idle[p];
            receiver_stall_pct = phase_stall[p];
            sent = 0;
            while (sent < 4) begin
                size = $urandom_range(1, 5);
                case ($urandom_range(0, 7))
                    0: pattern = PAT_ASCENDING;
                    1: pattern = PAT_DESCENDING;
                    2: pattern = PAT_EQUAL;
                    default: pattern = PAT_RANDOM;
                endcase
                send_set(size, pattern);
                sent += size;
            end
            wait_for_results(4);
        end
    endtask

    // The result side: random stalls, plus a long hold-off when one is requested.
    always @(negedge aclk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_sorted.size() == 0) begin
                $error("unexpected result: sorted_value %0d", m_payload.sorted_value);
                check_failures++;
            end else begin
                want = expected_sorted.pop_front();
                if (m_payload.sorted_value !== want.sorted_value) begin
                    $error("sorted_value: expected %0d, actual %0d",
                           want.sorted_value, m_payload.sorted_value);
                    check_failures++;
                end
                if (m_payload.last_of_run !== want.last_of_run) begin
                    $error("last_of_run: expected %0b, actual %0b",
                           want.last_of_run, m_payload.last_of_run);
                    check_failures++;
                end
                if (m_payload.overflow !== want.overflow) begin
                    $error("overflow: expected %0b, actual %0b",
                           want.overflow, m_payload.overflow);
                    check_failures++;
                end
            end
        end
    end

    initial begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_small_sets();
        test_store_limits();
        test_backpressure();
        test_random_sets();
        wait_for_results(50);
        if (check_failures == 0 && expected_sorted.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
